### rtl/pcgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcgm_pkg;
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_EOS  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_QW = 3'd0,
        CFG_QX = 3'd1,
        CFG_QY = 3'd2,
        CFG_QZ = 3'd3,
        CFG_PX = 3'd4,
        CFG_PY = 3'd5,
        CFG_PZ = 3'd6
    } cfg_index_t;

    localparam logic [7:0] DECAY_STEP = 8'd20;
    localparam logic [11:0] INTENSITY_GAIN = 12'd2550;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } pose_t;
endpackage
`default_nettype wire

### rtl/pcgm_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined rotation and projection: 5 stages, one point per cycle.
module pcgm_transform #(
    parameter int MAP_ROWS         = 256,
    parameter int MAP_COLS         = 256,
    parameter int PIXELS_PER_METER = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire pcgm_pkg::pose_t     pose,
    input  wire logic signed [15:0]  vx,
    input  wire logic signed [15:0]  vy,
    input  wire logic signed [15:0]  vz,
    output logic                     out_valid,
    output logic signed [31:0]       col,
    output logic signed [31:0]       row
);
    localparam int CW = 26;
    logic [4:0] vld_reg;
    // stage 1: t = u x v (Q22)
    logic signed [33:0] tx_reg, ty_reg, tz_reg;
    logic signed [15:0] v1x_reg, v1y_reg;
    // stage 2: products for s and w*t
    logic signed [50:0] a1_reg, a2_reg, b1_reg, b2_reg, wx_reg, wy_reg;
    logic signed [15:0] v2x_reg, v2y_reg;
    // stage 3: rotated + position (Q36)
    logic signed [55:0] rx_reg, ry_reg;
    // stage 4: scaled + centre
    logic signed [63:0] gx_reg, gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    function automatic logic signed [31:0] rnd(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        begin
            mag = v[63] ? 64'(-v) : 64'(v);
            r = (mag + (64'd1 << 35)) >> 36;
            rnd = v[63] ? -32'(signed'(r[31:0])) : 32'(signed'(r[31:0]));
        end
    endfunction

    always_ff @(posedge clk)
    begin
        tx_reg <= 34'(pose.qy * vz) - 34'(pose.qz * vy);
        ty_reg <= 34'(pose.qz * vx) - 34'(pose.qx * vz);
        tz_reg <= 34'(pose.qx * vy) - 34'(pose.qy * vx);
        v1x_reg <= vx;
        v1y_reg <= vy;
        a1_reg <= 51'(pose.qy * tz_reg);
        a2_reg <= 51'(pose.qz * ty_reg);
        b1_reg <= 51'(pose.qz * tx_reg);
        b2_reg <= 51'(pose.qx * tz_reg);
        wx_reg <= 51'(pose.qw * tx_reg);
        wy_reg <= 51'(pose.qw * ty_reg);
        v2x_reg <= v1x_reg;
        v2y_reg <= v1y_reg;
        rx_reg <= (56'(v2x_reg) <<< 28) + (56'(wx_reg) <<< 1)
                  + ((56'(a1_reg) - 56'(a2_reg)) <<< 1) + (56'(pose.px) <<< 28);
        ry_reg <= (56'(v2y_reg) <<< 28) + (56'(wy_reg) <<< 1)
                  + ((56'(b1_reg) - 56'(b2_reg)) <<< 1) + (56'(pose.py) <<< 28);
        gx_reg <= 64'(rx_reg) * 64'(CW'(PIXELS_PER_METER))
                  + (64'(MAP_COLS / 2) <<< 36);
        gy_reg <= 64'(ry_reg) * 64'(CW'(PIXELS_PER_METER))
                  + (64'(MAP_ROWS / 2) <<< 36);
        col <= rnd(gx_reg);
        row <= rnd(gy_reg);
    end

    assign out_valid = vld_reg[4];
endmodule
`default_nettype wire

### rtl/pcgm_grid_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pcgm_grid_ram #(
    parameter int AW = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/point_cloud_grid_mapper_unit.sv
// Grid mapper. Each start transaction yields one result strobe (result_valid),
// which the receiver must take in that cycle. The result of an add-point passes
// through the 5-stage transform, map read, update and result register; a read
// through map read, update and result register; an end-of-scanline through the
// result register alone, or first through the decay sweep, one map entry per cycle
// through the map memory. busy drops in the result cycle. After reset a clearing
// sweep of every map entry runs with busy high; configuration is accepted always.
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_grid_mapper_unit #(
    parameter int MAP_ROWS         = 256,
    parameter int MAP_COLS         = 256,
    parameter int PIXELS_PER_METER = 10,
    parameter int DECAY_PERIOD     = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic signed [15:0] point_z,
    input  wire logic [12:0]        intensity,
    input  wire logic [7:0]         read_col,
    input  wire logic [7:0]         read_row,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    result_valid,
    output logic                    hit,
    output logic [7:0]              pixel_col,
    output logic [7:0]              pixel_row,
    output logic [7:0]              pixel_value,
    output logic                    decayed
);
    localparam int CB = $clog2(MAP_COLS);
    localparam int RB = $clog2(MAP_ROWS);
    localparam int AW = CB + RB;
    localparam int DEPTH = MAP_ROWS * MAP_COLS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_XFORM = 8'b00000100,
        S_RD    = 8'b00001000,
        S_UPD   = 8'b00010000,
        S_SWEEP = 8'b00100000,
        S_SWB   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    pcgm_pkg::pose_t pose_reg;
    logic [5:0] scan_reg;
    logic [AW:0] cnt_reg;
    logic [AW-1:0] addr_reg, waddr_reg;
    logic [1:0] op_reg;
    logic [12:0] inten_reg;
    logic [7:0] rc_reg, rr_reg;
    logic in_map_reg;
    logic xf_valid;
    logic signed [31:0] xf_col, xf_row;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0] wdata, rdata;
    logic [12:0] term;
    logic [13:0] pix_sum;
    logic [7:0] nv;
    logic sweep_ok;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pcgm_pkg::CFG_QW: pose_reg.qw <= cfg_data;
                pcgm_pkg::CFG_QX: pose_reg.qx <= cfg_data;
                pcgm_pkg::CFG_QY: pose_reg.qy <= cfg_data;
                pcgm_pkg::CFG_QZ: pose_reg.qz <= cfg_data;
                pcgm_pkg::CFG_PX: pose_reg.px <= cfg_data;
                pcgm_pkg::CFG_PY: pose_reg.py <= cfg_data;
                default: ;
            endcase
        end
    end

    pcgm_transform #(
        .MAP_ROWS(MAP_ROWS), .MAP_COLS(MAP_COLS), .PIXELS_PER_METER(PIXELS_PER_METER)
    ) u_xform (
        .clk(clk), .rst_n(rst_n),
        .in_valid(state_reg == S_IDLE && start && opcode == pcgm_pkg::OP_ADD),
        .pose(pose_reg),
        .vx(point_x), .vy(point_y), .vz(point_z),
        .out_valid(xf_valid), .col(xf_col), .row(xf_row)
    );

    pcgm_grid_ram #(.AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign term = 13'((25'(inten_reg) * 25'(pcgm_pkg::INTENSITY_GAIN)) >> 12);
    assign pix_sum = 14'(term) + 14'(rdata);
    assign nv = (pix_sum[13:1] > 13'd255) ? 8'hFF : pix_sum[8:1];

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = waddr_reg;
        wdata = nv;
        raddr = addr_reg;
        sweep_ok = (cnt_reg == (AW+1)'(DEPTH));
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = cnt_reg[AW-1:0];
                wdata = '0;
                if (cnt_reg == (AW+1)'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        pcgm_pkg::OP_ADD:  state_next = S_XFORM;
                        pcgm_pkg::OP_READ: state_next = S_RD;
                        pcgm_pkg::OP_EOS:
                            state_next = ((7'(scan_reg) + 7'd1) > 7'(DECAY_PERIOD)) ?
                                         S_SWEEP : S_DONE;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_XFORM:
            begin
                if (xf_valid)
                    state_next = S_RD;
            end
            S_RD: state_next = S_UPD;
            S_UPD:
            begin
                if (op_reg == pcgm_pkg::OP_ADD && in_map_reg)
                    we = 1'b1;
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                raddr = cnt_reg[AW-1:0];
                we = (cnt_reg != '0);
                wdata = (rdata > pcgm_pkg::DECAY_STEP) ?
                        rdata - pcgm_pkg::DECAY_STEP : 8'd0;
                if (sweep_ok)
                    state_next = S_DONE;
            end
            S_SWB: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            scan_reg <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid <= (state_reg == S_DONE);
            if (state_reg == S_CLEAR || state_reg == S_SWEEP)
                cnt_reg <= (state_next == state_reg) ? cnt_reg + 1'b1 : '0;
            if (state_reg == S_IDLE && start && opcode == pcgm_pkg::OP_EOS)
                scan_reg <= (state_next == S_SWEEP) ? 6'd0 : scan_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SWEEP)
            waddr_reg <= cnt_reg[AW-1:0];
        if (state_reg == S_IDLE && start)
        begin
            op_reg <= opcode;
            inten_reg <= intensity;
            rc_reg <= read_col;
            rr_reg <= read_row;
            in_map_reg <= (32'(read_col) < 32'(MAP_COLS)) && (32'(read_row) < 32'(MAP_ROWS));
            addr_reg <= AW'((RB+CB+16)'(read_row) * (RB+CB+16)'(MAP_COLS)
                        + (RB+CB+16)'(read_col));
            hit <= 1'b0;
            pixel_col <= '0;
            pixel_row <= '0;
            pixel_value <= '0;
            decayed <= 1'b0;
        end
        if (state_reg == S_XFORM && xf_valid)
        begin
            in_map_reg <= xf_col >= 0 && xf_col < 32'(MAP_COLS)
                          && xf_row >= 0 && xf_row < 32'(MAP_ROWS);
            addr_reg <= AW'(64'(xf_row) * 64'(MAP_COLS) + 64'(xf_col));
            rc_reg <= xf_col[7:0];
            rr_reg <= xf_row[7:0];
        end
        if (state_reg == S_UPD)
        begin
            if (op_reg == pcgm_pkg::OP_ADD && in_map_reg)
            begin
                hit <= 1'b1;
                pixel_col <= rc_reg;
                pixel_row <= rr_reg;
                pixel_value <= nv;
            end
            else if (op_reg == pcgm_pkg::OP_READ)
            begin
                pixel_col <= rc_reg;
                pixel_row <= rr_reg;
                pixel_value <= in_map_reg ? rdata : 8'd0;
            end
        end
        if (state_reg == S_RD)
            waddr_reg <= addr_reg;
        if (state_reg == S_SWEEP && sweep_ok)
            decayed <= 1'b1;
    end
endmodule
`default_nettype wire

### rtl/pcgm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pcgm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic result_valid,
    input wire logic hit,
    input wire logic decayed
);
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("double result");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(hit && decayed)) else $error("hit and decayed");
endmodule
bind point_cloud_grid_mapper_unit pcgm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .hit(hit), .decayed(decayed)
);
`default_nettype wire

### bench/point_cloud_grid_mapper_unit_tb.sv
`timescale 1ns / 1ps
module point_cloud_grid_mapper_unit_tb;
    localparam int MAP_ROWS = 256;
    localparam int MAP_COLS = 256;
    localparam int PPM = 10;
    localparam int DECAY_PERIOD = 32;

    typedef struct {
        pcgm_pkg::opcode_t  op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [12:0]        inten;
        logic [7:0]         col;
        logic [7:0]         row;
    } sonar_item_t;

    typedef struct {
        logic       hit;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] value;
        logic       decayed;
    } pixel_result_t;

    logic clk, rst_n;
    logic start, busy;
    logic [1:0] opcode;
    logic signed [15:0] point_x, point_y, point_z;
    logic [12:0] intensity;
    logic [7:0] read_col, read_row;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic result_valid, hit, decayed;
    logic [7:0] pixel_col, pixel_row, pixel_value;

    point_cloud_grid_mapper_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .intensity(intensity), .read_col(read_col), .read_row(read_row),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .hit(hit),
        .pixel_col(pixel_col), .pixel_row(pixel_row), .pixel_value(pixel_value),
        .decayed(decayed)
    );

    sonar_item_t   pending_q[$];
    pixel_result_t expected_q[$];
    logic [7:0]    grid[MAP_ROWS * MAP_COLS];
    logic [5:0]    scanlines;
    logic signed [15:0] pose[7];
    logic [7:0]    hit_cols[$];
    logic [7:0]    hit_rows[$];
    int            idle_pct;
    bit            took;
    bit            failed;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint round_half_away(longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) <<< 35)) >>> 36;
        return (v < 0) ? -r : r;
    endfunction

    function automatic pixel_result_t map_item(sonar_item_t it);
        pixel_result_t res;
        longint w, ux, uy, uz, vx, vy, vz, tx, ty, tz, sxv, syv, rx, ry, px, py;
        int idx, term, nv;
        res = '{0, 0, 0, 0, 0};
        case (it.op)
            pcgm_pkg::OP_ADD:
            begin
                w = pose[pcgm_pkg::CFG_QW]; ux = pose[pcgm_pkg::CFG_QX];
                uy = pose[pcgm_pkg::CFG_QY]; uz = pose[pcgm_pkg::CFG_QZ];
                vx = it.x; vy = it.y; vz = it.z;
                tx = uy * vz - uz * vy;
                ty = uz * vx - ux * vz;
                tz = ux * vy - uy * vx;
                sxv = uy * tz - uz * ty;
                syv = uz * tx - ux * tz;
                rx = (vx <<< 28) + 2 * w * tx + 2 * sxv
                     + (longint'(pose[pcgm_pkg::CFG_PX]) <<< 28);
                ry = (vy <<< 28) + 2 * w * ty + 2 * syv
                     + (longint'(pose[pcgm_pkg::CFG_PY]) <<< 28);
                px = round_half_away(rx * PPM + (longint'(MAP_COLS / 2) <<< 36));
                py = round_half_away(ry * PPM + (longint'(MAP_ROWS / 2) <<< 36));
                if (px >= 0 && px < MAP_COLS && py >= 0 && py < MAP_ROWS)
                begin
                    idx = int'(py) * MAP_COLS + int'(px);
                    term = (int'(it.inten) * 2550) >> 12;
                    nv = (term + int'(grid[idx])) / 2;
                    if (nv > 255)
                        nv = 255;
                    grid[idx] = nv[7:0];
                    res.hit = 1;
                    res.col = px[7:0];
                    res.row = py[7:0];
                    res.value = nv[7:0];
                    hit_cols.push_back(px[7:0]);
                    hit_rows.push_back(py[7:0]);
                end
            end
            pcgm_pkg::OP_EOS:
            begin
                scanlines = scanlines + 6'd1;
                if (scanlines > DECAY_PERIOD)
                begin
                    foreach (grid[i])
                        grid[i] = (grid[i] > pcgm_pkg::DECAY_STEP) ?
                                  grid[i] - pcgm_pkg::DECAY_STEP : 8'd0;
                    scanlines = 0;
                    res.decayed = 1;
                end
            end
            pcgm_pkg::OP_READ:
            begin
                res.col = it.col;
                res.row = it.row;
                if (it.col < MAP_COLS && it.row < MAP_ROWS)
                    res.value = grid[int'(it.row) * MAP_COLS + int'(it.col)];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
        end
        else if (!(start && !took))
        begin
            took = 0;
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                sonar_item_t it;
                it = pending_q.pop_front();
                opcode <= it.op;
                point_x <= it.x;
                point_y <= it.y;
                point_z <= it.z;
                intensity <= it.inten;
                read_col <= it.col;
                read_row <= it.row;
                start <= 1;
            end
            else
            begin
                start <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sonar_item_t it;
                it.op = pcgm_pkg::opcode_t'(opcode);
                it.x = point_x; it.y = point_y; it.z = point_z;
                it.inten = intensity; it.col = read_col; it.row = read_row;
                expected_q.push_back(map_item(it));
                took = 1;
            end
            if (result_valid)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: none expected, got %0d/%0d/%0d/%0d/%0d",
                             $time, hit, pixel_col, pixel_row, pixel_value, decayed);
                    failed = 1;
                end
                else
                begin
                    pixel_result_t e;
                    e = expected_q.pop_front();
                    if (hit !== e.hit || pixel_col !== e.col || pixel_row !== e.row ||
                        pixel_value !== e.value || decayed !== e.decayed)
                    begin
                        $display("%0t: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                                 $time, e.hit, e.col, e.row, e.value, e.decayed,
                                 hit, pixel_col, pixel_row, pixel_value, decayed);
                        failed = 1;
                    end
                end
            end
        end
    end

    task automatic write_reg(pcgm_pkg::cfg_index_t idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pose[idx] = data;
    endtask

    task automatic set_pose(int qw, int qx, int qy, int qz, int px, int py, int pz);
        write_reg(pcgm_pkg::CFG_QW, qw[15:0]);
        write_reg(pcgm_pkg::CFG_QX, qx[15:0]);
        write_reg(pcgm_pkg::CFG_QY, qy[15:0]);
        write_reg(pcgm_pkg::CFG_QZ, qz[15:0]);
        write_reg(pcgm_pkg::CFG_PX, px[15:0]);
        write_reg(pcgm_pkg::CFG_PY, py[15:0]);
        write_reg(pcgm_pkg::CFG_PZ, pz[15:0]);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic queue_item(pcgm_pkg::opcode_t op, int x, int y, int z, int inten,
                              int c, int r);
        sonar_item_t it;
        it.op = op; it.x = x[15:0]; it.y = y[15:0]; it.z = z[15:0];
        it.inten = inten[12:0]; it.col = c[7:0]; it.row = r[7:0];
        pending_q.push_back(it);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || start || expected_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        int sel, c, r, k, span;
        repeat (count)
        begin
            sel = $urandom_range(99);
            span = ($urandom_range(99) < 85) ? 3400 : 32768;
            if (sel < 55)
                queue_item(pcgm_pkg::OP_ADD, $urandom_range(2 * span - 1) - span,
                           $urandom_range(2 * span - 1) - span, $urandom,
                           ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(4096),
                           $urandom, $urandom);
            else if (sel < 67)
                queue_item(pcgm_pkg::OP_EOS, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
            else if (sel < 95)
            begin
                if (hit_cols.size() > 0 && $urandom_range(9) < 7)
                begin
                    k = $urandom_range(hit_cols.size() - 1);
                    c = hit_cols[k];
                    r = hit_rows[k];
                end
                else
                begin
                    c = $urandom_range(255);
                    r = $urandom_range(255);
                end
                queue_item(pcgm_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, c, r);
            end
            else
                queue_item(pcgm_pkg::OP_NOP, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        opcode = pcgm_pkg::OP_NOP;
        point_x = 0; point_y = 0; point_z = 0;
        intensity = 0; read_col = 0; read_row = 0;
        cfg_valid = 0; cfg_index = pcgm_pkg::CFG_QW; cfg_data = 0;
        took = 0;
        failed = 0;
        idle_pct = 18;
        foreach (grid[i])
            grid[i] = 0;
        scanlines = 0;
        pose[pcgm_pkg::CFG_QW] = 16384;
        for (int i = 1; i < 7; i++)
            pose[i] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        set_pose(16384, 0, 0, 0, 0, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, 0, 0, 0, 4096, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, 0, 0, 0, 0, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, 3251, -3277, 32767, 8191, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, 3264, 0, -32768, 4096, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, -3277, 3251, 0, 2048, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, -3290, -3290, 0, 4096, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, 32767, 32767, 32767, 4096, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, -32768, -32768, -32768, 4096, 0, 0);
        queue_item(pcgm_pkg::OP_ADD, 13, -13, 0, 8191, 0, 0);
        queue_item(pcgm_pkg::OP_READ, 0, 0, 0, 0, 128, 128);
        queue_item(pcgm_pkg::OP_READ, 0, 0, 0, 0, 255, 0);
        queue_item(pcgm_pkg::OP_READ, 0, 0, 0, 0, 0, 255);
        queue_item(pcgm_pkg::OP_READ, 0, 0, 0, 0, 255, 255);
        queue_item(pcgm_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        queue_item(pcgm_pkg::OP_EOS, 0, 0, 0, 0, 0, 0);
        queue_item(pcgm_pkg::OP_NOP, -1, -1, -1, 8191, 255, 255);
        queue_item(pcgm_pkg::OP_READ, 0, 0, 0, 0, 127, 128);
        queue_random(110);
        drain();

        set_pose(11585, 0, 0, 11585, 512, -768, 1000);
        queue_random(125);
        drain();

        idle_pct = 66;
        set_pose(-16384, 16384, -16384, 16384, 32767, -32768, -32768);
        queue_random(40);
        drain();
        set_pose(8192, -8192, 8192, -8192, -32768, 32767, 32767);
        queue_random(40);
        drain();
        set_pose(14189, 4096, -4096, 6000, -300, 250, 0);
        queue_random(50);
        drain();

        idle_pct = 0;
        set_pose(16384, 0, 0, 0, 0, 0, 0);
        queue_random(125);
        drain();
        repeat (20) @(posedge clk);

        if (!failed && expected_q.size() == 0)
            $display("point_cloud_grid_mapper_unit: match");
        else
            $display("point_cloud_grid_mapper_unit: mismatch");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("point_cloud_grid_mapper_unit: mismatch");
        $finish;
    end
endmodule

### point_cloud_grid_mapper_unit.f
rtl/pcgm_pkg.sv
rtl/pcgm_transform.sv
rtl/pcgm_grid_ram.sv
rtl/point_cloud_grid_mapper_unit.sv
rtl/pcgm_checker.sv
bench/point_cloud_grid_mapper_unit_tb.sv
